// File: design/cpoly_pkg.sv
// Shared types and constants for the closed polyline perimeter block.
// No dependencies; imported by the front end, back end and top level (not by the queue).
package cpoly_pkg;

    // Width of the closed-shape tolerance register (unsigned, Q.12)
    localparam int TOL_BITS = 23;

    // Per-request control word passed from the front end to the back end
    typedef struct packed {
        logic seg_valid;  // add the segment from the previous vertex
        logic last;       // add the closing segment and emit a result
        logic is_closed;  // first and last vertex within tolerance
    } job_flags_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_ROOT,
        BK_ACC,
        BK_EMIT
    } back_state_t;

endpackage

// File: design/cpoly_fifo.sv
// Small request queue between the front end and the back end.
// Uses no package items; data width and depth come from parameters.
module cpoly_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [DATA_W-1:0]   slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/cpoly_front.sv
// Front end: accepts vertices, tracks first/previous vertex, builds requests.
// Depends on cpoly_pkg for the request flags and tolerance width.
module cpoly_front
    import cpoly_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic                  last_point,
    input  logic [TOL_BITS-1:0]   closed_tolerance,
    output logic                  q_push,
    input  logic                  q_full,
    output job_flags_t            q_flags,
    output logic [COORD_BITS-1:0] q_seg_dx,
    output logic [COORD_BITS-1:0] q_seg_dy,
    output logic [COORD_BITS-1:0] q_cls_dx,
    output logic [COORD_BITS-1:0] q_cls_dy
);
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int CMP_BITS  = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;

    logic                  have_first_reg, have_first_next;
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [COORD_BITS-1:0] ref_x, ref_y;
    logic signed [DIFF_BITS-1:0] sdx, sdy, cdx, cdy;
    logic                  accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // closing reference is the stored first vertex, or this vertex if it starts the list
    assign ref_x = have_first_reg ? first_x_reg : point_x;
    assign ref_y = have_first_reg ? first_y_reg : point_y;

    // signed differences, one extra bit so they never wrap
    assign sdx = $signed({point_x[COORD_BITS-1], point_x})
               - $signed({prev_x_reg[COORD_BITS-1], prev_x_reg});
    assign sdy = $signed({point_y[COORD_BITS-1], point_y})
               - $signed({prev_y_reg[COORD_BITS-1], prev_y_reg});
    assign cdx = $signed({point_x[COORD_BITS-1], point_x})
               - $signed({ref_x[COORD_BITS-1], ref_x});
    assign cdy = $signed({point_y[COORD_BITS-1], point_y})
               - $signed({ref_y[COORD_BITS-1], ref_y});

    // magnitudes fit in COORD_BITS unsigned bits
    always_comb begin
        q_seg_dx = sdx[DIFF_BITS-1] ? COORD_BITS'(-sdx) : sdx[COORD_BITS-1:0];
        q_seg_dy = sdy[DIFF_BITS-1] ? COORD_BITS'(-sdy) : sdy[COORD_BITS-1:0];
        q_cls_dx = cdx[DIFF_BITS-1] ? COORD_BITS'(-cdx) : cdx[COORD_BITS-1:0];
        q_cls_dy = cdy[DIFF_BITS-1] ? COORD_BITS'(-cdy) : cdy[COORD_BITS-1:0];
    end

    // request classification; a first vertex that is not last needs no back-end work
    always_comb begin
        q_flags.seg_valid = have_first_reg;
        q_flags.last      = last_point;
        q_flags.is_closed = (CMP_BITS'(q_cls_dx) <= CMP_BITS'(closed_tolerance))
                         && (CMP_BITS'(q_cls_dy) <= CMP_BITS'(closed_tolerance));
        q_push            = accept && (have_first_reg || last_point);
    end

    always_comb begin
        have_first_next = have_first_reg;
        if (accept) begin
            have_first_next = !last_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
        end else begin
            have_first_reg <= have_first_next;
        end
    end

    // vertex history
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_x_reg <= point_x;
            prev_y_reg <= point_y;
            if (!have_first_reg) begin
                first_x_reg <= point_x;
                first_y_reg <= point_y;
            end
        end
    end

endmodule

// File: design/cpoly_back.sv
// Back end: squares, bit-serial square root and saturating sum per segment,
// plus the result register. Depends on cpoly_pkg for flags and state enum.
module cpoly_back
    import cpoly_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int SUM_BITS   = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    input  job_flags_t            job_flags,
    input  logic [COORD_BITS-1:0] job_seg_dx,
    input  logic [COORD_BITS-1:0] job_seg_dy,
    input  logic [COORD_BITS-1:0] job_cls_dx,
    input  logic [COORD_BITS-1:0] job_cls_dy,
    output logic                  job_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUM_BITS-1:0]   out_perimeter,
    output logic                  out_is_closed,
    output logic                  out_saturated
);
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 1;
    localparam int CNT_BITS  = $clog2(ROOT_BITS);
    localparam int ACC_BITS  = ((SUM_BITS > ROOT_BITS) ? SUM_BITS : ROOT_BITS) + 1;
    localparam logic [SUM_BITS-1:0] SUM_MAX  = '1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROOT_BITS - 1);

    back_state_t           state_reg, state_next;
    logic                  which_reg;  // 0: segment from previous, 1: closing segment
    logic [SQ_BITS-1:0]    sq_x_reg, sq_y_reg;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [REM_BITS-1:0]   rem_reg, rem_next;
    logic [ROOT_BITS-1:0]  root_reg, root_next;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SUM_BITS-1:0]   sum_reg, sum_sat;
    logic [ACC_BITS-1:0]   acc_sum;
    logic                  out_valid_reg;
    logic [SUM_BITS-1:0]   out_perim_reg;
    logic                  out_closed_reg, out_sat_reg;
    logic [COORD_BITS-1:0] op_a, op_b;
    logic                  out_free, out_load, start;
    logic [REM_BITS+1:0]   rem_sh, trial, rem_diff;
    logic                  fits;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (job_valid) state_next = BK_MUL;
            end
            BK_MUL:  state_next = BK_ADD;
            BK_ADD:  state_next = BK_ROOT;
            BK_ROOT: begin
                if (cnt_reg == CNT_LAST) state_next = BK_ACC;
            end
            BK_ACC: begin
                if (!job_flags.last) begin
                    state_next = BK_IDLE;
                end else if (!which_reg) begin
                    state_next = BK_MUL;
                end else begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        start    = 1'b0;
        job_pop  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE: start    = job_valid;
            BK_ACC:  job_pop  = !job_flags.last;
            BK_EMIT: begin
                out_load = out_free;
                job_pop  = out_free;
            end
            default: begin
                start = 1'b0;
            end
        endcase
    end

    // operand select for the squaring stage
    assign op_a = which_reg ? job_cls_dx : job_seg_dx;
    assign op_b = which_reg ? job_cls_dy : job_seg_dy;

    // one restoring root step: bring down two radicand bits, try (root << 2) | 1
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial     = (REM_BITS + 2)'({root_reg, 2'b01});
        fits      = (rem_sh >= trial);
        rem_diff  = rem_sh - trial;
        rem_next  = fits ? rem_diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
        root_next = {root_reg[ROOT_BITS-2:0], fits};
    end

    // saturating accumulate of the finished root
    assign acc_sum = ACC_BITS'(sum_reg) + ACC_BITS'(root_reg);
    assign sum_sat = (acc_sum > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_BITS-1:0];

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_ACC) begin
                sum_reg <= sum_sat;
            end else if (out_load) begin
                sum_reg <= '0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            which_reg <= !job_flags.seg_valid;
        end else if (state_reg == BK_ACC && !which_reg) begin
            which_reg <= 1'b1;
        end
        if (state_reg == BK_MUL) begin
            sq_x_reg <= SQ_BITS'(op_a) * SQ_BITS'(op_a);
            sq_y_reg <= SQ_BITS'(op_b) * SQ_BITS'(op_b);
        end
        if (state_reg == BK_ADD) begin
            rad_reg  <= RAD_BITS'(sq_x_reg) + RAD_BITS'(sq_y_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (state_reg == BK_ROOT) begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (out_load) begin
            out_perim_reg  <= sum_reg;
            out_closed_reg <= job_flags.is_closed;
            out_sat_reg    <= (sum_reg == SUM_MAX);
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_perimeter = out_perim_reg;
    assign out_is_closed = out_closed_reg;
    assign out_saturated = out_sat_reg;

    // a result appears only from the emit state
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == BK_EMIT))
        else $error("result register loaded outside emit");

    // the running sum restarts after every emitted result
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (sum_reg == '0))
        else $error("running sum not cleared after result");

    // saturated flag agrees with the captured perimeter
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_sat_reg == (out_perim_reg == SUM_MAX)))
        else $error("saturated flag mismatch");

    // the queue head is released only when its work is finished
    a_pop_done: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> (state_reg == BK_ACC || state_reg == BK_EMIT))
        else $error("request popped mid-computation");

endmodule

// File: design/closed_polyline_perimeter.sv
// Top level of the closed polyline perimeter block: tolerance register,
// front end, request queue and back end. Depends on cpoly_pkg and all cpoly_* modules.
//
// Vertices arrive one per request on the s_ stream (x, y signed Q11.12, tlast on the
// final vertex); one result per list leaves on the m_ stream with the perimeter in Q.12,
// saturated at 2^SUM_BITS-1. Every vertex after the first passes through the back end
// as start, square, sum, one root bit per cycle over COORD_BITS+1 bits, and accumulate.
// The last vertex of a longer list runs its own segment, then the closing segment, then
// the result state; a single-vertex list runs only the closing segment and the result.
// The back end is the limit: the front end takes vertices as long as the two-entry
// request queue has room. A result waiting on m_tready stalls the back end only once
// the next result is ready. closed_tolerance is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce this.
module closed_polyline_perimeter
    import cpoly_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int SUM_BITS   = 40,
    localparam int S_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((SUM_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [TOL_BITS-1:0] cfg_wr_data,   // closed_tolerance
    // vertex stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,       // point_x, point_y, zero pad
    input  logic                s_tlast,       // last_point
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,       // perimeter, zero pad
    output logic [1:0]          m_tuser        // is_closed, saturated
);
    localparam int JOB_W = 4 * COORD_BITS + $bits(job_flags_t);

    logic [TOL_BITS-1:0]   tol_reg;
    logic                  q_push, q_full, q_pop, q_empty;
    job_flags_t            f_flags, b_flags;
    logic [COORD_BITS-1:0] f_seg_dx, f_seg_dy, f_cls_dx, f_cls_dy;
    logic [COORD_BITS-1:0] b_seg_dx, b_seg_dy, b_cls_dx, b_cls_dy;
    logic [JOB_W-1:0]      q_wdata, q_rdata;
    logic [SUM_BITS-1:0]   perimeter;
    logic                  is_closed, saturated;

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    cpoly_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .point_x          (s_tdata[COORD_BITS-1:0]),
        .point_y          (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .last_point       (s_tlast),
        .closed_tolerance (tol_reg),
        .q_push           (q_push),
        .q_full           (q_full),
        .q_flags          (f_flags),
        .q_seg_dx         (f_seg_dx),
        .q_seg_dy         (f_seg_dy),
        .q_cls_dx         (f_cls_dx),
        .q_cls_dy         (f_cls_dy)
    );

    // request packing
    assign q_wdata = {f_flags, f_cls_dy, f_cls_dx, f_seg_dy, f_seg_dx};
    assign {b_flags, b_cls_dy, b_cls_dx, b_seg_dy, b_seg_dx} = q_rdata;

    cpoly_fifo #(
        .DATA_W (JOB_W),
        .DEPTH  (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    cpoly_back #(
        .COORD_BITS (COORD_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (!q_empty),
        .job_flags     (b_flags),
        .job_seg_dx    (b_seg_dx),
        .job_seg_dy    (b_seg_dy),
        .job_cls_dx    (b_cls_dx),
        .job_cls_dy    (b_cls_dy),
        .job_pop       (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_perimeter (perimeter),
        .out_is_closed (is_closed),
        .out_saturated (saturated)
    );

    assign m_tdata = M_DATA_W'(perimeter);
    assign m_tuser = {saturated, is_closed};

endmodule

// File: dv/perimeter_tb_pkg.sv
// Perimeter tracker for the closed polyline perimeter testbench: a cycle-free
// model of the block plus the queue of perimeters it still owes. No dependencies.
package perimeter_tb_pkg;

    localparam longint unsigned PERIM_MAX = 64'h0000_00FF_FFFF_FFFF;

    typedef struct {
        logic [39:0] perimeter;
        logic        is_closed;
        logic        saturated;
    } perim_result_t;

    class perimeter_ledger;
        longint          first_x, first_y, prev_x, prev_y;
        longint unsigned run_sum;
        bit              open_list;
        logic [22:0]     tolerance;
        perim_result_t   owed_q[$];
        int              errors, vertices, perimeters, closed_count, saturated_count;

        function new();
            first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
            run_sum = 0; open_list = 0; tolerance = '0;
            errors = 0; vertices = 0; perimeters = 0;
            closed_count = 0; saturated_count = 0;
        endfunction

        function void set_tolerance(logic [22:0] tol);
            tolerance = tol;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        static function longint unsigned span(longint a, longint b);
            return (a >= b) ? longint'(a - b) : longint'(b - a);
        endfunction

        // floor of the square root, built one result bit at a time from the top
        static function longint unsigned floor_root(longint unsigned n);
            longint unsigned root, trial;
            root = 0;
            for (int i = 31; i >= 0; i--) begin
                trial = root | (64'd1 << i);
                if (trial * trial <= n) root = trial;
            end
            return root;
        endfunction

        static function longint unsigned seg_length(longint ax, longint ay,
                                                    longint bx, longint by);
            longint unsigned dx, dy;
            dx = span(ax, bx);
            dy = span(ay, by);
            return floor_root(dx * dx + dy * dy);
        endfunction

        // sum that sticks at the 40-bit maximum
        static function longint unsigned sat_sum(longint unsigned s, longint unsigned d);
            if (s >= PERIM_MAX || d > PERIM_MAX - s) return PERIM_MAX;
            return s + d;
        endfunction

        // accepted vertex request: x in the low half, y in the high half
        function void note_vertex(logic [47:0] data, logic last);
            longint        x, y;
            perim_result_t res;
            x = longint'($signed(data[23:0]));
            y = longint'($signed(data[47:24]));
            vertices++;
            if (!open_list) begin
                first_x = x;
                first_y = y;
                run_sum = 0;
                open_list = 1;
            end else begin
                run_sum = sat_sum(run_sum, seg_length(prev_x, prev_y, x, y));
            end
            prev_x = x;
            prev_y = y;
            if (last) begin
                // closing segment back to the first vertex
                run_sum = sat_sum(run_sum, seg_length(x, y, first_x, first_y));
                res.perimeter = run_sum[39:0];
                res.is_closed = (span(first_x, x) <= tolerance) &&
                                (span(first_y, y) <= tolerance);
                res.saturated = (run_sum == PERIM_MAX);
                owed_q.push_back(res);
                run_sum = 0;
                open_list = 0;
            end
        endfunction

        // accepted result request against the oldest owed perimeter
        function void check_perimeter(logic [39:0] perim, logic closed, logic sat);
            perim_result_t want;
            if (owed_q.size() == 0) begin
                $error("perimeter %0d arrived with no list finished", perim);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            perimeters++;
            if (want.is_closed) closed_count++;
            if (want.saturated) saturated_count++;
            if (perim !== want.perimeter) begin
                $error("perimeter: expected %0d, actual %0d", want.perimeter, perim);
                errors++;
            end
            if (closed !== want.is_closed) begin
                $error("is_closed: expected %0b, actual %0b", want.is_closed, closed);
                errors++;
            end
            if (sat !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, sat);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench for closed_polyline_perimeter: drives vertex lists in paced
// bursts, stalls the result side, and checks every perimeter against perimeter_tb_pkg.
// Depends on cpoly_pkg, perimeter_tb_pkg and the design folder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cpoly_pkg::TOL_BITS;
    import perimeter_tb_pkg::*;

    localparam int COORD_MIN    = -8388608;
    localparam int COORD_MAX    = 8388607;
    localparam int TOL_MAX      = (1 << TOL_BITS) - 1;
    localparam int SETTLE_TICKS = 100;        // two root passes plus margin
    localparam int LONG_HOLD    = 3000;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum {SPAN_FULL, SPAN_EDGE, SPAN_LOCAL} coord_span_t;
    typedef enum {RX_OPEN, RX_COIN, RX_TIGHT} rx_pattern_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [TOL_BITS-1:0] cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [47:0]         s_tdata;     // point_x, point_y
    logic                s_tlast;     // last_point
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;     // perimeter
    logic [1:0]          m_tuser;     // is_closed, saturated

    perimeter_ledger ledger;
    int              burst_left = 1;
    int              hold_ticket = 0;
    int              settings_used = 0;

    closed_polyline_perimeter dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        int ticks;
        ticks = 0;
        while (ticks < CYCLE_LIMIT) begin
            @(posedge aclk);
            ticks++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // both handshakes, sampled on the edge before any update lands
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) ledger.note_vertex(s_tdata, s_tlast);
            if (m_tvalid && m_tready) ledger.check_perimeter(m_tdata, m_tuser[0], m_tuser[1]);
        end
    end

    // result side: stretches of open, coin-flip and mostly-stalled ready,
    // plus a long hold-off whenever the main sequence bumps hold_ticket
    initial begin
        int          stretch;
        int          hold_left;
        int          seen;
        rx_pattern_t pattern;
        stretch = 0;
        hold_left = 0;
        seen = 0;
        pattern = RX_OPEN;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ticket != seen) begin
                seen = hold_ticket;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(5, 150);
                    pattern = rx_pattern_t'($urandom_range(0, 2));
                end
                stretch--;
                case (pattern)
                    RX_OPEN: begin
                        m_tready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // one vertex request; paced requests close a burst with a random gap
    task automatic offer_vertex(input int x, input int y, input bit last, input bit paced);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {y[23:0], x[23:0]};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (paced) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    endtask

    // stop sending, wait for every owed perimeter, then let the back end go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_tolerance(input int tol);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tol[TOL_BITS-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ledger.set_tolerance(tol[TOL_BITS-1:0]);
        settings_used++;
    endtask

    function automatic int rand_coord(coord_span_t sp);
        case (sp)
            SPAN_FULL: begin
                return int'($urandom_range(0, 16777215)) - 8388608;
            end
            SPAN_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: begin
                return int'($urandom_range(0, 16383)) - 8192;
            end
        endcase
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // random lists; a third of them end near the first vertex to probe the tolerance
    task automatic run_random_lists(input int count, input int tol);
        int          sent, len, pick, fx, fy, x, y, reach;
        coord_span_t sp;
        sent = 0;
        reach = tol + 2;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) len = $urandom_range(1, 3);
            else if (pick < 8) len = $urandom_range(4, 10);
            else len = $urandom_range(11, 30);
            sp = coord_span_t'($urandom_range(0, 2));
            fx = 0;
            fy = 0;
            for (int i = 0; i < len; i++) begin
                x = rand_coord(sp);
                y = rand_coord(sp);
                if (i == 0) begin
                    fx = x;
                    fy = y;
                end else if (i == len - 1 && $urandom_range(0, 2) == 0) begin
                    x = clamp_coord(fx + int'($urandom_range(0, 2 * reach)) - reach);
                    y = clamp_coord(fy + int'($urandom_range(0, 2 * reach)) - reach);
                end
                offer_vertex(x, y, i == len - 1, 1'b1);
            end
            sent += len;
        end
    endtask

    initial begin
        int tols[4];
        ledger = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // tolerance at its reset value: single vertex, extremes, zero length, 3-4-5
        offer_vertex(0, 0, 1'b1, 1'b0);
        offer_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        offer_vertex(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        offer_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        offer_vertex(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        offer_vertex(0, 0, 1'b0, 1'b0);
        offer_vertex(3 * 4096, 0, 1'b0, 1'b0);
        offer_vertex(3 * 4096, 4 * 4096, 1'b1, 1'b0);
        offer_vertex(-1, -1, 1'b0, 1'b0);
        offer_vertex(1, 1, 1'b0, 1'b0);
        offer_vertex(0, 0, 1'b0, 1'b0);
        offer_vertex(-1, 1, 1'b1, 1'b0);
        settle_block();

        // one unit of tolerance: gap equal to it closes, one more does not
        write_tolerance(4096);
        offer_vertex(0, 0, 1'b0, 1'b0);
        offer_vertex(100, 0, 1'b0, 1'b0);
        offer_vertex(4096, -4096, 1'b1, 1'b0);
        offer_vertex(0, 0, 1'b0, 1'b0);
        offer_vertex(4097, 0, 1'b1, 1'b0);
        offer_vertex(-4096, 5000, 1'b0, 1'b0);
        offer_vertex(0, 5000, 1'b1, 1'b0);
        settle_block();

        // widest tolerance against the widest gaps
        write_tolerance(TOL_MAX);
        offer_vertex(COORD_MIN, 0, 1'b0, 1'b0);
        offer_vertex(COORD_MAX, 0, 1'b1, 1'b0);
        offer_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        offer_vertex(-1, -1, 1'b1, 1'b0);
        settle_block();

        // random lists under several tolerance settings
        tols[0] = $urandom_range(0, 16384);
        tols[1] = 0;
        tols[2] = TOL_MAX;
        tols[3] = $urandom_range(0, TOL_MAX);
        foreach (tols[k]) begin
            write_tolerance(tols[k]);
            run_random_lists(165, tols[k]);
            settle_block();
        end

        // back-pressure: result side held off while single-vertex lists keep coming
        hold_ticket++;
        for (int i = 0; i < 40; i++) begin
            offer_vertex(rand_coord(SPAN_FULL), rand_coord(SPAN_FULL), 1'b1, 1'b0);
        end
        settle_block();

        if (ledger.pending() != 0) begin
            $error("%0d perimeters never arrived", ledger.pending());
            ledger.errors++;
        end
        $display("Run covered %0d vertices and %0d perimeters over %0d tolerance settings",
                 ledger.vertices, ledger.perimeters, settings_used);
        $display("  %0d shapes reported closed, %0d perimeters pinned at the maximum",
                 ledger.closed_count, ledger.saturated_count);
        if (ledger.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/cpoly_pkg.sv
design/cpoly_fifo.sv
design/cpoly_front.sv
design/cpoly_back.sv
design/closed_polyline_perimeter.sv
dv/perimeter_tb_pkg.sv
dv/testbench.sv
